// ----- src/mbapd_pkg.sv -----
package mbapd_pkg;

  localparam int FRAME_MAX_DEF = 256;
  localparam int HEADER_BYTES  = 7;

  localparam logic [2:0] ST_HDR_BYTE   = 3'd0;
  localparam logic [2:0] ST_HDR_DONE   = 3'd1;
  localparam logic [2:0] ST_PDU_BYTE   = 3'd2;
  localparam logic [2:0] ST_FRAME_DONE = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;
  localparam logic [2:0] ST_LEN_ERR    = 3'd5;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  byte_out;
    logic [7:0]  frame_index;
    logic [15:0] transaction_id;
    logic [15:0] protocol_id;
    logic [15:0] frame_length;
    logic [7:0]  unit_id;
  } result_t;

endpackage

// ----- src/mbap_frame_deframer.sv -----
// Modbus TCP MBAP deframer, cut-through.
// Input channel: one stream byte per transaction (data_byte, in_valid/in_ready).
// Output channel: one status transaction per input byte (status, byte_out,
// frame_index and the decoded header fields, out_valid/out_ready).
// The first seven bytes of a frame form the MBAP header; the seventh byte
// reports header done (or length error if the length field is below two),
// then length-1 pdu bytes follow and the last one reports frame done.
// A pdu byte arriving once the frame position reaches FRAME_MAX is dropped
// and reported as an overflow abort; the deframer then restarts on a header.
// A result is registered in the result buffer when its byte is accepted.
// Throughput: one byte per cycle while the result buffer has room, set by the
// counter and header register update that each byte goes through.
// A two-entry result buffer decouples the sides: in_ready only drops when
// two results wait, so a stalled receiver holds the input after two bytes.
// Reset (rst, synchronous) empties the buffer and returns to header phase.
module mbap_frame_deframer #(
  parameter int FRAME_MAX = mbapd_pkg::FRAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  byte_out,
  output logic [7:0]  frame_index,
  output logic [15:0] transaction_id,
  output logic [15:0] protocol_id,
  output logic [15:0] frame_length,
  output logic [7:0]  unit_id
);
  import mbapd_pkg::*;

  localparam int POS_BITS = $clog2(FRAME_MAX + 1);
  localparam int POS_W    = (POS_BITS > 8) ? POS_BITS : 8;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_MAX);

  logic             in_pdu_phase;
  logic [2:0]       header_left;
  logic [15:0]      pdu_left;
  logic [POS_W-1:0] position;
  logic [55:0]      header_fields;

  logic             in_pdu_phase_next;
  logic [2:0]       header_left_next;
  logic [15:0]      pdu_left_next;
  logic [POS_W-1:0] position_next;
  logic [55:0]      header_fields_next;

  logic [55:0]      hdr_shift;
  logic [15:0]      len;
  logic             accept;
  logic             restart;
  result_t          res;
  result_t          res_out;

  assign accept    = in_valid && in_ready;
  assign hdr_shift = {header_fields[47:0], data_byte};
  assign len       = hdr_shift[23:8];

  always_comb begin
    in_pdu_phase_next  = in_pdu_phase;
    header_left_next   = header_left;
    pdu_left_next      = pdu_left;
    position_next      = position + POS_W'(1);
    header_fields_next = header_fields;
    restart            = 1'b0;

    res.byte_out       = data_byte;
    res.frame_index    = position[7:0];
    res.status         = ST_PDU_BYTE;
    res.transaction_id = header_fields[55:40];
    res.protocol_id    = header_fields[39:24];
    res.frame_length   = header_fields[23:8];
    res.unit_id        = header_fields[7:0];

    if (!in_pdu_phase) begin
      header_fields_next = hdr_shift;
      header_left_next   = header_left - 3'd1;
      res.transaction_id = hdr_shift[55:40];
      res.protocol_id    = hdr_shift[39:24];
      res.frame_length   = len;
      res.unit_id        = hdr_shift[7:0];
      if (header_left_next != 3'd0) begin
        res.status         = ST_HDR_BYTE;
        res.transaction_id = 16'd0;
        res.protocol_id    = 16'd0;
        res.frame_length   = 16'd0;
        res.unit_id        = 8'd0;
      end else if (len < 16'd2) begin
        res.status = ST_LEN_ERR;
        restart    = 1'b1;
      end else begin
        res.status        = ST_HDR_DONE;
        pdu_left_next     = len - 16'd1;
        in_pdu_phase_next = 1'b1;
      end
    end else if (position >= POS_LIMIT) begin
      res.status   = ST_OVERFLOW;
      res.byte_out = 8'd0;
      restart      = 1'b1;
    end else begin
      pdu_left_next = pdu_left - 16'd1;
      if (pdu_left_next == 16'd0) begin
        res.status = ST_FRAME_DONE;
        restart    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && restart)) begin
      in_pdu_phase  <= 1'b0;
      header_left   <= 3'(HEADER_BYTES);
      pdu_left      <= 16'd0;
      position      <= '0;
      header_fields <= 56'd0;
    end else if (accept) begin
      in_pdu_phase  <= in_pdu_phase_next;
      header_left   <= header_left_next;
      pdu_left      <= pdu_left_next;
      position      <= position_next;
      header_fields <= header_fields_next;
    end
  end

  mbapd_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (res_out)
  );

  assign status         = res_out.status;
  assign byte_out       = res_out.byte_out;
  assign frame_index    = res_out.frame_index;
  assign transaction_id = res_out.transaction_id;
  assign protocol_id    = res_out.protocol_id;
  assign frame_length   = res_out.frame_length;
  assign unit_id        = res_out.unit_id;

endmodule

// ----- src/mbapd_skid.sv -----
module mbapd_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  mbapd_pkg::result_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mbapd_pkg::result_t pop_data
);
  import mbapd_pkg::*;

  // two-entry buffer so the upstream ready never waits on the downstream one
  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mbapd_pkg::*;

  localparam int FRAME_MAX     = FRAME_MAX_DEF;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_BYTES  = 1000;
  localparam int PRINT_LIMIT   = 50;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  byte_out;
  logic [7:0]  frame_index;
  logic [15:0] transaction_id;
  logic [15:0] protocol_id;
  logic [15:0] frame_length;
  logic [7:0]  unit_id;

  mbap_frame_deframer u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .byte_out       (byte_out),
    .frame_index    (frame_index),
    .transaction_id (transaction_id),
    .protocol_id    (protocol_id),
    .frame_length   (frame_length),
    .unit_id        (unit_id)
  );

  // deframer state as seen by the predictor
  logic        in_pdu;
  logic [2:0]  hdr_left;
  logic [15:0] pdu_left;
  int          frame_pos;
  logic [55:0] hdr_shift;

  result_t pending_status[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      stall_cycles = 0;
  bit      steady = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void restart_frame();
    in_pdu    = 1'b0;
    hdr_left  = 3'd7;
    pdu_left  = 16'd0;
    frame_pos = 0;
    hdr_shift = '0;
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    r             = '0;
    r.byte_out    = b;
    r.frame_index = frame_pos[7:0];
    if (!in_pdu) begin
      hdr_shift = {hdr_shift[47:0], b};
      frame_pos++;
      hdr_left  = hdr_left - 3'd1;
    end
    {r.transaction_id, r.protocol_id, r.frame_length, r.unit_id} = hdr_shift;
    if (!in_pdu) begin
      if (hdr_left != 3'd0) begin
        r.status = ST_HDR_BYTE;
        {r.transaction_id, r.protocol_id, r.frame_length, r.unit_id} = '0;
      end else if (hdr_shift[23:8] < 16'd2) begin
        r.status = ST_LEN_ERR;
        restart_frame();
      end else begin
        pdu_left = hdr_shift[23:8] - 16'd1;
        in_pdu   = 1'b1;
        r.status = ST_HDR_DONE;
      end
    end else if (frame_pos >= FRAME_MAX) begin
      // byte is dropped, frame aborted
      r.status   = ST_OVERFLOW;
      r.byte_out = 8'h00;
      restart_frame();
    end else begin
      frame_pos++;
      pdu_left = pdu_left - 16'd1;
      if (pdu_left == 16'd0) begin
        r.status = ST_FRAME_DONE;
        restart_frame();
      end else begin
        r.status = ST_PDU_BYTE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  // pdu bytes stop at the first one that overflows the frame
  task automatic send_frame(input logic [15:0] tid, input logic [15:0] pid,
                            input logic [15:0] len, input logic [7:0] uid);
    int n_pdu;
    n_pdu = (len < 16'd2) ? 0 : int'(len) - 1;
    if (n_pdu > FRAME_MAX - HEADER_BYTES + 1) n_pdu = FRAME_MAX - HEADER_BYTES + 1;
    send_byte(tid[15:8]);
    send_byte(tid[7:0]);
    send_byte(pid[15:8]);
    send_byte(pid[7:0]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(uid);
    repeat (n_pdu) send_byte(8'($urandom));
  endtask

  task automatic test_short_frames();
    send_frame(16'h0000, 16'h0000, 16'd2, 8'h00);
    send_frame(16'hFFFF, 16'hFFFF, 16'd3, 8'hFF);
    send_frame(16'h5AA5, 16'h0000, 16'd2, 8'h11);
  endtask

  task automatic test_length_errors();
    send_frame(16'h1234, 16'h0000, 16'd0, 8'h01);
    send_frame(16'hFFFF, 16'hFFFF, 16'd1, 8'hFF);
  endtask

  task automatic test_overflow();
    // largest frame that still completes, then the first that aborts, then one with length FFFF
    send_frame(16'h0102, 16'h0000, 16'd250, 8'h07);
    send_frame(16'h0304, 16'h0000, 16'd251, 8'h08);
    send_frame(16'hA5A5, 16'h5A5A, 16'hFFFF, 8'h80);
  endtask

  task automatic test_random_stream();
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      steady = (bytes_sent - start >= 400) && (bytes_sent - start < 700);
      pick = $urandom_range(0, 99);
      if (pick < 72)
        send_frame(16'($urandom), 16'($urandom), 16'($urandom_range(2, 24)), 8'($urandom));
      else if (pick < 80)
        send_frame(16'($urandom), 16'($urandom), 16'($urandom_range(0, 1)), 8'($urandom));
      else if (pick < 85)
        send_frame(16'($urandom), 16'($urandom), 16'($urandom_range(200, 250)),
                   8'($urandom));
      else if (pick < 90)
        send_frame(16'($urandom), 16'($urandom), 16'($urandom_range(251, 65535)),
                   8'($urandom));
      else
        repeat ($urandom_range(1, 40)) send_byte(8'($urandom));
    end
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {status, byte_out, frame_index, transaction_id, protocol_id, frame_length,
             unit_id};
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, status %0d", got.status));
      end else begin
        want = pending_status.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.byte_out !== want.byte_out)
          report_mismatch($sformatf("byte_out %h, expected %h", got.byte_out, want.byte_out));
        if (got.frame_index !== want.frame_index)
          report_mismatch($sformatf("frame_index %0d, expected %0d",
                                    got.frame_index, want.frame_index));
        if (got.transaction_id !== want.transaction_id)
          report_mismatch($sformatf("transaction_id %h, expected %h",
                                    got.transaction_id, want.transaction_id));
        if (got.protocol_id !== want.protocol_id)
          report_mismatch($sformatf("protocol_id %h, expected %h",
                                    got.protocol_id, want.protocol_id));
        if (got.frame_length !== want.frame_length)
          report_mismatch($sformatf("frame_length %h, expected %h",
                                    got.frame_length, want.frame_length));
        if (got.unit_id !== want.unit_id)
          report_mismatch($sformatf("unit_id %h, expected %h", got.unit_id, want.unit_id));
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    restart_frame();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_short_frames();
    test_length_errors();
    test_overflow();
    test_random_stream();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- mbap_frame_deframer.f -----
src/mbapd_pkg.sv
src/mbapd_skid.sv
src/mbap_frame_deframer.sv
sim/tb_top.sv
